// ----- rtl/tds_pkg.sv -----
`default_nettype none
package tds_pkg;

	localparam int READY_DEPTH_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int TID_W   = 10;
	localparam int PID_W   = 10;
	localparam int PRIO_W  = 8;
	localparam int EV_W    = 3;
	localparam int COUNT_W = 5;
	localparam int STAMP_W = 16;
	localparam int QUANT_W = 16;
	localparam int ALG_W   = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// One ready memory word: {stamp, priority, pid, tid}.
	localparam int ENTRY_W = STAMP_W + PRIO_W + PID_W + TID_W;

	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CPU_AVAIL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

	localparam logic [EV_W-1:0] EV_NONE = 3'd0;
	localparam logic [EV_W-1:0] EV_DISPATCHED = 3'd1;
	localparam logic [EV_W-1:0] EV_QUANTUM_IRQ = 3'd2;
	localparam logic [EV_W-1:0] EV_READY_EMPTY = 3'd3;
	localparam logic [EV_W-1:0] EV_CPU_BUSY = 3'd4;
	localparam logic [EV_W-1:0] EV_READY_FULL = 3'd5;

	localparam logic [ALG_W-1:0] ALG_FIFO = 2'd0;
	localparam logic [ALG_W-1:0] ALG_PRIORITY = 2'd1;
	localparam logic [ALG_W-1:0] ALG_ROUND_ROBIN = 2'd2;
	localparam logic [ALG_W-1:0] ALG_INVALID = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_MS = 2'd1;

	localparam logic [ALG_W-1:0]   ALG_RESET = ALG_FIFO;
	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd100;

	typedef struct packed {
		logic capture;
		logic do_simple;
		logic start_scan;
		logic enq_write;
		logic scan_rd;
		logic dispatch;
		logic load_out;
	} tds_cmd_t;

	typedef struct packed {
		logic need_find;
		logic need_scan;
		logic slot_free;
	} tds_status_t;

endpackage
`default_nettype wire

// ----- rtl/thread_dispatch_scheduler.sv -----
`default_nettype none
// Single-CPU thread scheduler with a ready store of READY_DEPTH entries held in one
// single-port-read memory. Every input transaction yields exactly one result transaction,
// and items are handled one at a time. Tick, release, an enqueue into a full store and
// any cpu-available item that does not dispatch go from the decide state straight to the
// result state. Any other enqueue walks the valid bits from slot 0 to the lowest free
// slot and writes the entry there; a dispatch reads every slot of the ready memory through
// its one read port, then passes the drain and dispatch states. A result that is not
// taken holds the block until the output register frees up. A new item is accepted while
// the previous result still waits in the output register. Configuration writes are taken
// at any time but must only be issued while the block is idle.
module thread_dispatch_scheduler
	import tds_pkg::*;
#(
	parameter int READY_DEPTH = READY_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [TID_W-1:0]      thread_id,
	input  wire logic [PID_W-1:0]      process_id,
	input  wire logic [PRIO_W-1:0]     priority_req,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [EV_W-1:0]       event_res,
	output logic      [TID_W-1:0]      out_thread_id,
	output logic      [PID_W-1:0]      out_process_id,
	output logic      [COUNT_W-1:0]    ready_count,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	tds_cmd_t                         cmd;
	tds_status_t                      status;
	logic [$clog2(READY_DEPTH)-1:0]   idx;

	tds_ctrl #(
		.READY_DEPTH(READY_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd),
		.idx      (idx)
	);

	tds_datapath #(
		.READY_DEPTH(READY_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.idx           (idx),
		.status        (status),
		.command       (command),
		.thread_id     (thread_id),
		.process_id    (process_id),
		.priority_req  (priority_req),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.event_res     (event_res),
		.out_thread_id (out_thread_id),
		.out_process_id(out_process_id),
		.ready_count   (ready_count)
	);

endmodule
`default_nettype wire

// ----- rtl/tds_ram.sv -----
`default_nettype none
module tds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tds_datapath.sv -----
`default_nettype none
module tds_datapath
	import tds_pkg::*;
#(
	parameter int READY_DEPTH = READY_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tds_cmd_t                       cmd,
	input  wire logic [$clog2(READY_DEPTH)-1:0] idx,
	output tds_status_t                         status,
	input  wire logic [CMD_W-1:0]               command,
	input  wire logic [TID_W-1:0]               thread_id,
	input  wire logic [PID_W-1:0]               process_id,
	input  wire logic [PRIO_W-1:0]              priority_req,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_data,
	output logic      [EV_W-1:0]                event_res,
	output logic      [TID_W-1:0]               out_thread_id,
	output logic      [PID_W-1:0]               out_process_id,
	output logic      [COUNT_W-1:0]             ready_count
);

	localparam int IDX_W = $clog2(READY_DEPTH);
	localparam int CNT_W = $clog2(READY_DEPTH + 1);

	// Captured input transaction.
	logic [CMD_W-1:0]  cmd_q;
	logic [TID_W-1:0]  tid_q;
	logic [PID_W-1:0]  pid_q;
	logic [PRIO_W-1:0] prio_q;

	logic [ALG_W-1:0]   algorithm_q;
	logic [QUANT_W-1:0] quantum_q;

	logic [READY_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [STAMP_W-1:0]     arrival_q;
	logic                   busy_q;
	logic [TID_W-1:0]       run_tid_q;
	logic [PID_W-1:0]       run_pid_q;
	logic [QUANT_W-1:0]     q_left_q;
	logic                   q_armed_q;

	logic [EV_W-1:0]  pend_ev_q;
	logic [TID_W-1:0] pend_tid_q;
	logic [PID_W-1:0] pend_pid_q;

	logic             rd_s1;
	logic [IDX_W-1:0] addr_s1;

	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [TID_W-1:0]  best_tid_q;
	logic [PID_W-1:0]  best_pid_q;

	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;

	logic [STAMP_W-1:0] rd_stamp;
	logic [PRIO_W-1:0]  rd_prio;
	logic [PID_W-1:0]   rd_pid;
	logic [TID_W-1:0]   rd_tid;
	logic [PRIO_W-1:0]  key_prio;
	logic [STAMP_W-1:0] rd_age;
	logic               better;
	logic               take;

	logic full;
	logic empty;
	logic [QUANT_W-1:0] q_dec;
	logic [EV_W-1:0]  simple_ev;
	logic [TID_W-1:0] simple_tid;
	logic [PID_W-1:0] simple_pid;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign cfg_ready = 1'b1;

	assign full  = (count_q == CNT_W'(READY_DEPTH));
	assign empty = (count_q == '0);

	assign status.need_find = (cmd_q == CMD_ENQUEUE) && !full;
	assign status.need_scan = (cmd_q == CMD_CPU_AVAIL) && !empty &&
		(algorithm_q != ALG_INVALID) && !busy_q;
	assign status.slot_free = !valid_q[idx];

	assign wr_data = {arrival_q, prio_q, pid_q, tid_q};

	tds_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(READY_DEPTH)
	) u_ready_ram (
		.clk  (clk),
		.we   (cmd.enq_write),
		.waddr(idx),
		.wdata(wr_data),
		.re   (cmd.scan_rd),
		.raddr(idx),
		.rdata(rd_data)
	);

	assign {rd_stamp, rd_prio, rd_pid, rd_tid} = rd_data;
	assign key_prio = (algorithm_q == ALG_FIFO) ? '0 : rd_prio;
	assign rd_age   = arrival_q - rd_stamp;
	assign better   = !best_found_q || (key_prio < best_prio_q) ||
		((key_prio == best_prio_q) && (rd_age > best_age_q));
	assign take     = rd_s1 && valid_q[addr_s1] && better;

	assign q_dec = (q_left_q != '0) ? q_left_q - QUANT_W'(1) : q_left_q;

	// Results of the commands that finish without touching the ready memory.
	always_comb begin
		simple_ev  = EV_NONE;
		simple_tid = '0;
		simple_pid = '0;
		case (cmd_q)
			CMD_ENQUEUE: begin
				simple_ev = EV_READY_FULL;
			end
			CMD_CPU_AVAIL: begin
				if (empty) begin
					simple_ev = EV_READY_EMPTY;
				end else if (algorithm_q == ALG_INVALID) begin
					simple_ev = EV_CPU_BUSY;
				end else if (algorithm_q == ALG_PRIORITY) begin
					simple_ev = EV_CPU_BUSY;
				end
			end
			CMD_TICK: begin
				if (q_armed_q && (q_dec == '0) && busy_q) begin
					simple_ev  = EV_QUANTUM_IRQ;
					simple_tid = run_tid_q;
					simple_pid = run_pid_q;
				end
			end
			default: begin
				simple_ev = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			tid_q  <= thread_id;
			pid_q  <= process_id;
			prio_q <= priority_req;
		end
		if (cmd.do_simple) begin
			pend_ev_q  <= simple_ev;
			pend_tid_q <= simple_tid;
			pend_pid_q <= simple_pid;
		end else if (cmd.enq_write) begin
			pend_ev_q  <= EV_NONE;
			pend_tid_q <= '0;
			pend_pid_q <= '0;
		end else if (cmd.dispatch) begin
			pend_ev_q  <= EV_DISPATCHED;
			pend_tid_q <= best_tid_q;
			pend_pid_q <= best_pid_q;
		end
		addr_s1 <= idx;
		if (take) begin
			best_idx_q  <= addr_s1;
			best_prio_q <= key_prio;
			best_age_q  <= rd_age;
			best_tid_q  <= rd_tid;
			best_pid_q  <= rd_pid;
		end
	end

	assign count_ext = (CNT_W + COUNT_W)'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			event_res      <= pend_ev_q;
			out_thread_id  <= pend_tid_q;
			out_process_id <= pend_pid_q;
			ready_count    <= count_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algorithm_q  <= ALG_RESET;
			quantum_q    <= QUANTUM_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			arrival_q    <= '0;
			busy_q       <= 1'b0;
			run_tid_q    <= '0;
			run_pid_q    <= '0;
			q_left_q     <= '0;
			q_armed_q    <= 1'b0;
			rd_s1        <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ALGORITHM) begin
					algorithm_q <= cfg_data[ALG_W-1:0];
				end else if (cfg_index == REG_QUANTUM_MS) begin
					quantum_q <= cfg_data[QUANT_W-1:0];
				end
			end
			rd_s1 <= cmd.scan_rd;
			if (cmd.start_scan) begin
				best_found_q <= 1'b0;
			end else if (take) begin
				best_found_q <= 1'b1;
			end
			if (cmd.enq_write) begin
				valid_q[idx] <= 1'b1;
				count_q      <= count_q + CNT_W'(1);
				arrival_q    <= arrival_q + STAMP_W'(1);
			end
			if (cmd.dispatch) begin
				valid_q[best_idx_q] <= 1'b0;
				count_q   <= count_q - CNT_W'(1);
				busy_q    <= 1'b1;
				run_tid_q <= best_tid_q;
				run_pid_q <= best_pid_q;
				if (algorithm_q == ALG_ROUND_ROBIN) begin
					q_left_q  <= (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
					q_armed_q <= 1'b1;
				end else begin
					q_left_q  <= '0;
					q_armed_q <= 1'b0;
				end
			end
			if (cmd.do_simple) begin
				if (cmd_q == CMD_TICK) begin
					if (q_armed_q) begin
						q_left_q <= q_dec;
						if (q_dec == '0) begin
							q_armed_q <= 1'b0;
						end
					end
				end else if (cmd_q == CMD_RELEASE) begin
					busy_q    <= 1'b0;
					q_armed_q <= 1'b0;
					q_left_q  <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tds_ctrl.sv -----
`default_nettype none
module tds_ctrl
	import tds_pkg::*;
#(
	parameter int READY_DEPTH = READY_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	input  wire tds_status_t                    status,
	output tds_cmd_t                            cmd,
	output logic      [$clog2(READY_DEPTH)-1:0] idx
);

	localparam int IDX_W = $clog2(READY_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DECIDE   = 7'b0000010,
		S_FIND     = 7'b0000100,
		S_SCAN     = 7'b0001000,
		S_DRAIN    = 7'b0010000,
		S_DISPATCH = 7'b0100000,
		S_RESULT   = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             last;
	logic             out_free;

	assign last      = (cnt_q == IDX_W'(READY_DEPTH - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = cnt_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cnt_d = '0;
				if (status.need_find) begin
					state_d = S_FIND;
				end else if (status.need_scan) begin
					cmd.start_scan = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.do_simple = 1'b1;
					state_d       = S_RESULT;
				end
			end
			S_FIND: begin
				// The store is known not to be full, so a free slot turns up.
				if (status.slot_free) begin
					cmd.enq_write = 1'b1;
					state_d       = S_RESULT;
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (last) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				cmd.dispatch = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_thread_dispatch_scheduler.sv -----
`default_nettype none
module tb_thread_dispatch_scheduler
	import tds_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = READY_DEPTH_DEF;
	localparam int TOTAL_ITEMS    = 1320;
	localparam int QUIET_FROM     = 1120;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = SLOTS + 12;
	localparam int PRINT_CAP      = 30;
	localparam int PLAN_ROWS      = 27;

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [TID_W-1:0]   tid;
		logic [PID_W-1:0]   pid;
		logic [COUNT_W-1:0] count;
	} sched_result_t;

	typedef enum bit {ROW_ITEM, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CMD_W-1:0]   cmd;
		logic [TID_W-1:0]   tid;
		logic [PID_W-1:0]   pid;
		logic [PRIO_W-1:0]  prio;
		logic [ALG_W-1:0]   alg;
		logic [QUANT_W-1:0] quantum;
		bit                 pinned;
		logic [EV_W-1:0]    ev;
		logic [TID_W-1:0]   otid;
		logic [PID_W-1:0]   opid;
		logic [COUNT_W-1:0] count;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic [TID_W-1:0]      thread_id;
	logic [PID_W-1:0]      process_id;
	logic [PRIO_W-1:0]     priority_req;
	logic                  out_valid;
	logic                  out_ready;
	logic [EV_W-1:0]       event_res;
	logic [TID_W-1:0]      out_thread_id;
	logic [PID_W-1:0]      out_process_id;
	logic [COUNT_W-1:0]    ready_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	thread_dispatch_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.thread_id(thread_id),
		.process_id(process_id),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.out_thread_id(out_thread_id),
		.out_process_id(out_process_id),
		.ready_count(ready_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Scheduler shadow state, as it stands after every accepted transaction.
	logic [TID_W-1:0]   rq_tid   [SLOTS];
	logic [PID_W-1:0]   rq_pid   [SLOTS];
	logic [PRIO_W-1:0]  rq_prio  [SLOTS];
	logic [STAMP_W-1:0] rq_stamp [SLOTS];
	bit                 rq_live  [SLOTS] = '{default: 1'b0};
	logic [STAMP_W-1:0] arrivals = '0;
	bit                 cpu_held = 1'b0;
	logic [TID_W-1:0]   run_tid = '0;
	logic [PID_W-1:0]   run_pid = '0;
	logic [QUANT_W-1:0] slice_left = '0;
	bit                 slice_armed = 1'b0;
	logic [ALG_W-1:0]   shadow_alg = ALG_RESET;
	logic [QUANT_W-1:0] shadow_quantum = QUANTUM_RESET;

	sched_result_t pending_results [$];
	sched_result_t pinned_result;
	bit            pin_next = 1'b0;
	bit            idle_on = 1'b1;
	int            items_taken = 0;
	int            cfg_writes = 0;
	int            idle_cycles = 0;
	int            failures = 0;
	int            event_tally [8] = '{default: 0};
	logic [QUANT_W-1:0] phase_quantum;

	// Directed opening: reset behavior, field extremes, every command, each mode,
	// quantum zero, the unused algorithm code and the busy and empty answers.
	plan_row_t plan_table [PLAN_ROWS] = '{
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_READY_EMPTY, 0, 0, 0},
		'{ROW_ITEM, CMD_TICK, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_RELEASE, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_ENQUEUE, 1023, 1023, 255, '0, '0, 1, EV_NONE, 0, 0, 1},
		'{ROW_ITEM, CMD_ENQUEUE, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 2},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_DISPATCHED, 1023, 1023, 1},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 1},
		'{ROW_ITEM, CMD_RELEASE, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 1},
		'{ROW_CONFIG, '0, 0, 0, 0, ALG_PRIORITY, 100, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_ENQUEUE, 5, 6, 0, '0, '0, 1, EV_NONE, 0, 0, 2},
		'{ROW_ITEM, CMD_ENQUEUE, 7, 8, 200, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_CPU_BUSY, 0, 0, 2},
		'{ROW_ITEM, CMD_RELEASE, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_CONFIG, '0, 0, 0, 0, ALG_ROUND_ROBIN, 0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_TICK, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_TICK, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_RELEASE, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_CONFIG, '0, 0, 0, 0, ALG_INVALID, 65535, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_CPU_BUSY, 0, 0, 1},
		'{ROW_CONFIG, '0, 0, 0, 0, ALG_ROUND_ROBIN, 2, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_TICK, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_RELEASE, 0, 0, 0, '0, '0, 0, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_TICK, 0, 0, 0, '0, '0, 1, EV_NONE, 0, 0, 0},
		'{ROW_ITEM, CMD_CPU_AVAIL, 0, 0, 0, '0, '0, 1, EV_READY_EMPTY, 0, 0, 0}
	};

	function automatic logic [COUNT_W-1:0] live_threads();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += rq_live[i];
		return COUNT_W'(n);
	endfunction

	// Advances the shadow scheduler by one transaction and returns its answer.
	function automatic sched_result_t schedule_step(input logic [CMD_W-1:0] cmd,
			input logic [TID_W-1:0] tid, input logic [PID_W-1:0] pid,
			input logic [PRIO_W-1:0] prio);
		sched_result_t res;
		int slot;
		int best;
		logic [PRIO_W-1:0] rank;
		logic [PRIO_W-1:0] best_rank;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] best_age;
		res = '{EV_NONE, '0, '0, '0};
		slot = -1;
		best = -1;
		best_rank = '0;
		best_age = '0;
		case (cmd)
			CMD_ENQUEUE: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!rq_live[i])
						slot = i;
				if (slot < 0) begin
					res.ev = EV_READY_FULL;
				end else begin
					rq_tid[slot] = tid;
					rq_pid[slot] = pid;
					rq_prio[slot] = prio;
					rq_stamp[slot] = arrivals;
					rq_live[slot] = 1'b1;
					arrivals = arrivals + 1'b1;
				end
			end
			CMD_CPU_AVAIL: begin
				if (live_threads() == 0) begin
					res.ev = EV_READY_EMPTY;
				end else if (shadow_alg == ALG_INVALID) begin
					res.ev = EV_CPU_BUSY;
				end else if (cpu_held) begin
					res.ev = (shadow_alg == ALG_PRIORITY) ? EV_CPU_BUSY : EV_NONE;
				end else begin
					// Age is measured back from the arrival counter, so stamps wrap safely.
					for (int i = 0; i < SLOTS; i++) begin
						if (rq_live[i]) begin
							rank = (shadow_alg == ALG_FIFO) ? '0 : rq_prio[i];
							age = arrivals - rq_stamp[i];
							if (best < 0 || rank < best_rank ||
									(rank == best_rank && age > best_age)) begin
								best = i;
								best_rank = rank;
								best_age = age;
							end
						end
					end
					rq_live[best] = 1'b0;
					cpu_held = 1'b1;
					run_tid = rq_tid[best];
					run_pid = rq_pid[best];
					res.ev = EV_DISPATCHED;
					res.tid = run_tid;
					res.pid = run_pid;
					slice_armed = (shadow_alg == ALG_ROUND_ROBIN);
					if (shadow_alg != ALG_ROUND_ROBIN)
						slice_left = '0;
					else if (shadow_quantum == 0)
						slice_left = 1;
					else
						slice_left = shadow_quantum;
				end
			end
			CMD_TICK: begin
				if (slice_armed) begin
					if (slice_left != 0)
						slice_left = slice_left - 1'b1;
					if (slice_left == 0) begin
						slice_armed = 1'b0;
						if (cpu_held) begin
							res.ev = EV_QUANTUM_IRQ;
							res.tid = run_tid;
							res.pid = run_pid;
						end
					end
				end
			end
			default: begin
				cpu_held = 1'b0;
				slice_armed = 1'b0;
				slice_left = '0;
			end
		endcase
		res.count = live_threads();
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (failures < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random stall bursts while idling is enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		sched_result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				cfg_writes++;
				case (cfg_index)
					REG_ALGORITHM: shadow_alg = cfg_data[ALG_W-1:0];
					REG_QUANTUM_MS: shadow_quantum = cfg_data[QUANT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				items_taken++;
				want = schedule_step(command, thread_id, process_id, priority_req);
				if (pin_next) begin
					want = pinned_result;
					pin_next = 1'b0;
				end
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				event_tally[event_res]++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, event", event_res, -1);
				end else begin
					want = pending_results.pop_front();
					if (event_res !== want.ev)
						report_mismatch("event_res", event_res, want.ev);
					if (out_thread_id !== want.tid)
						report_mismatch("out_thread_id", out_thread_id, want.tid);
					if (out_process_id !== want.pid)
						report_mismatch("out_process_id", out_process_id, want.pid);
					if (ready_count !== want.count)
						report_mismatch("ready_count", ready_count, want.count);
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so a back-to-back item never drops it.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid,
			input logic [PID_W-1:0] pid, input logic [PRIO_W-1:0] prio);
		int target;
		target = items_taken + 1;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		thread_id <= tid;
		process_id <= pid;
		priority_req <= prio;
		do @(negedge clk); while (items_taken < target);
	endtask

	task automatic send_noise(input logic [CMD_W-1:0] cmd);
		send_item(cmd, TID_W'($urandom), PID_W'($urandom), PRIO_W'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_config(input logic [ALG_W-1:0] alg, input logic [QUANT_W-1:0] q);
		int target;
		target = cfg_writes + 1;
		cfg_valid <= 1'b1;
		cfg_index <= REG_ALGORITHM;
		cfg_data <= CFG_DATA_W'(alg);
		do @(negedge clk); while (cfg_writes < target);
		cfg_index <= REG_QUANTUM_MS;
		cfg_data <= q;
		do @(negedge clk); while (cfg_writes < target + 1);
		cfg_valid <= 1'b0;
		phase_quantum = q;
	endtask

	function automatic logic [PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 9))
			0, 1, 2: return PRIO_W'($urandom_range(0, 3));
			3: return '0;
			4: return '1;
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	function automatic logic [QUANT_W-1:0] pick_quantum();
		case ($urandom_range(0, 19))
			0, 1, 2: return '0;
			3, 4: return '1;
			5, 6, 7, 8, 9: return QUANT_W'($urandom);
			default: return QUANT_W'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin
		int enq_max;
		int tick_span;
		int phase_end;
		logic [ALG_W-1:0] alg;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_ENQUEUE;
		thread_id = '0;
		process_id = '0;
		priority_req = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ALGORITHM;
		cfg_data = '0;
		phase_quantum = QUANTUM_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan_table[r]) begin
			if (plan_table[r].kind == ROW_CONFIG) begin
				drain_results();
				write_config(plan_table[r].alg, plan_table[r].quantum);
			end else begin
				if (plan_table[r].pinned) begin
					pinned_result = '{plan_table[r].ev, plan_table[r].otid,
						plan_table[r].opid, plan_table[r].count};
					pin_next = 1'b1;
				end
				send_item(plan_table[r].cmd, plan_table[r].tid, plan_table[r].pid,
					plan_table[r].prio);
			end
		end

		// Random phases. Each one starts from an idle block with a fresh setting and
		// runs mostly enqueue, dispatch, tick and release episodes.
		while (items_taken < TOTAL_ITEMS) begin
			drain_results();
			idle_on = (items_taken < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			alg = ($urandom_range(0, 9) == 0) ? ALG_INVALID : ALG_W'($urandom_range(0, 2));
			write_config(alg, pick_quantum());
			enq_max = $urandom_range(1, 5);
			tick_span = (phase_quantum <= 6) ? int'(phase_quantum) + 2 : 3;
			phase_end = items_taken + $urandom_range(30, 90);
			if (phase_end > TOTAL_ITEMS)
				phase_end = TOTAL_ITEMS;
			while (items_taken < phase_end) begin
				if ($urandom_range(0, 9) < 7) begin
					repeat ($urandom_range(0, enq_max))
						send_item(CMD_ENQUEUE, TID_W'($urandom), PID_W'($urandom),
							pick_priority());
					send_noise(CMD_CPU_AVAIL);
					repeat ($urandom_range(0, tick_span))
						send_noise(CMD_TICK);
					if ($urandom_range(0, 3) == 0)
						send_noise(CMD_CPU_AVAIL);
					if ($urandom_range(0, 4) != 0)
						send_noise(CMD_RELEASE);
				end else begin
					send_noise(CMD_W'($urandom_range(0, 3)));
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d transactions and %0d register writes across all modes",
			items_taken, cfg_writes);
		$display("dispatches %0d, interrupts %0d, empty %0d, busy %0d, drops %0d",
			event_tally[EV_DISPATCHED], event_tally[EV_QUANTUM_IRQ],
			event_tally[EV_READY_EMPTY], event_tally[EV_CPU_BUSY],
			event_tally[EV_READY_FULL]);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", failures);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
